[src/drpwd_pkg.sv]
// ---------------------------------------------------------------------------
// drpwd_pkg: shared types and constants of the DRAM request picker
// Word layouts, command codes, register indexes and the control/status
// bundles between controller and datapath.
// ---------------------------------------------------------------------------
package drpwd_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ENTRY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HIGH_MARK = 2'd0;
  localparam logic [1:0] REG_LOW_MARK  = 2'd1;
  localparam logic [1:0] REG_AGE       = 2'd2;

  localparam int CFG_DATA_W = 32;
  localparam int FIELD_TIME_W = 48;

  // register reset values
  localparam logic [7:0]  HIGH_MARK_RESET = 8'd80;
  localparam logic [7:0]  LOW_MARK_RESET  = 8'd40;
  localparam logic [31:0] AGE_RESET       = 32'd10000;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  channel;
    logic [7:0]  read_count;
    logic [7:0]  write_count;
    logic [47:0] now_cycle;
    logic        is_write;
    logic        issuable;
    logic        bank_active;
    logic [15:0] open_row;
    logic [15:0] entry_row;
    logic [47:0] arrive_cycle;
    logic [6:0]  entry_id;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic       chose_write;
    logic [6:0] chosen_id;
    logic       was_priority;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted word
    logic start;     // update drain flag, latch pass, clear picks
    logic classify;  // judge the held entry
    logic update;    // fold the judged entry into the picks
    logic emit;      // load the result register, clear picks
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       out_free;
  } dp_status_t;

endpackage

[src/drpwd_ctrl.sv]
// ---------------------------------------------------------------------------
// drpwd_ctrl: sequencing controller
// Accepts one word at a time and steps the datapath through decode,
// pick update and result load.
// ---------------------------------------------------------------------------
module drpwd_ctrl import drpwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.command)
          CMD_START: begin
            cmd.start = 1'b1;
            state_nxt = S_IDLE;
          end
          CMD_ENTRY: begin
            cmd.classify = 1'b1;
            state_nxt    = S_UPDATE;
          end
          CMD_FINISH: state_nxt = S_EMIT;
          default:    state_nxt = S_IDLE;  // unused code: drop the word
        endcase
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/drpwd_datapath.sv]
// ---------------------------------------------------------------------------
// drpwd_datapath: picker datapath
// Holds the configuration, drain flags, pass settings, the two running
// picks and the result register.
// ---------------------------------------------------------------------------
module drpwd_datapath import drpwd_pkg::*; #(
  parameter int CHANNELS  = 4,
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status
);

  localparam int TB = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
  localparam int AW = (TB > CFG_DATA_W) ? TB : CFG_DATA_W;

  // configuration
  logic [7:0]            high_r;
  logic [7:0]            low_r;
  logic [CFG_DATA_W-1:0] age_r;

  logic [CHANNELS-1:0]   drain_r;
  logic [CHANNELS-1:0]   drain_nxt;

  in_item_t              item_r;

  logic                  pass_drain_r;
  logic [TB-1:0]         pass_now_r;

  logic                  prio_valid_r;
  logic [TB-1:0]         prio_arrival_r;
  logic [6:0]            prio_id_r;
  logic                  any_valid_r;
  logic [TB-1:0]         any_arrival_r;
  logic [6:0]            any_id_r;

  logic                  cand_r;
  logic                  prio_cand_r;

  logic                  out_valid_r;
  out_item_t             out_r;
  out_item_t             out_nxt;

  // start decision
  logic                  ch_in_range;
  logic                  ch_flag_old;
  logic                  ch_flag_new;

  // entry judgement
  logic [TB-1:0]         arrival;
  logic [TB:0]           age_diff;
  logic                  is_hit;
  logic                  is_aged;
  logic                  considered;

  assign status.command  = item_r.command;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ch_in_range = (32'(item_r.channel) < CHANNELS);
    ch_flag_old = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(item_r.channel) == i) begin
        ch_flag_old = drain_r[i];
      end
    end
    priority if ((item_r.write_count > high_r) || (item_r.read_count == 8'd0)) begin
      ch_flag_new = 1'b1;
    end else if (item_r.write_count <= low_r) begin
      ch_flag_new = 1'b0;
    end else begin
      ch_flag_new = ch_flag_old;
    end
    drain_nxt = drain_r;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(item_r.channel) == i) begin
        drain_nxt[i] = ch_flag_new;
      end
    end
  end

  assign arrival    = item_r.arrive_cycle[TB-1:0];
  assign age_diff   = {1'b0, pass_now_r} - {1'b0, arrival};
  // a borrow means the entry arrived after the pass cycle: never aged
  assign is_aged    = !age_diff[TB] && (AW'(age_diff[TB-1:0]) > AW'(age_r));
  assign is_hit     = item_r.bank_active && (item_r.open_row == item_r.entry_row);
  assign considered = (item_r.is_write == pass_drain_r) && item_r.issuable;

  always_comb begin
    out_nxt = '0;
    priority if (prio_valid_r) begin
      out_nxt.found        = 1'b1;
      out_nxt.chose_write  = pass_drain_r;
      out_nxt.chosen_id    = prio_id_r;
      out_nxt.was_priority = 1'b1;
    end else if (any_valid_r) begin
      out_nxt.found       = 1'b1;
      out_nxt.chose_write = pass_drain_r;
      out_nxt.chosen_id   = any_id_r;
    end else begin
      out_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r       <= HIGH_MARK_RESET;
      low_r        <= LOW_MARK_RESET;
      age_r        <= AGE_RESET;
      drain_r      <= '0;
      pass_drain_r <= 1'b0;
      pass_now_r   <= '0;
      prio_valid_r <= 1'b0;
      any_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HIGH_MARK: high_r <= cfg_data[7:0];
          REG_LOW_MARK:  low_r  <= cfg_data[7:0];
          REG_AGE:       age_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        drain_r      <= drain_nxt;
        pass_drain_r <= ch_in_range && ch_flag_new;
        pass_now_r   <= item_r.now_cycle[TB-1:0];
      end
      if (cmd.start || cmd.emit) begin
        prio_valid_r <= 1'b0;
        any_valid_r  <= 1'b0;
      end
      if (cmd.update) begin
        if (prio_cand_r && (!prio_valid_r || (arrival < prio_arrival_r))) begin
          prio_valid_r <= 1'b1;
        end
        if (cand_r && (!any_valid_r || (arrival < any_arrival_r))) begin
          any_valid_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.classify) begin
      cand_r      <= considered;
      prio_cand_r <= considered && (is_hit || is_aged);
    end
    if (cmd.update) begin
      if (prio_cand_r && (!prio_valid_r || (arrival < prio_arrival_r))) begin
        prio_arrival_r <= arrival;
        prio_id_r      <= item_r.entry_id;
      end
      if (cand_r && (!any_valid_r || (arrival < any_arrival_r))) begin
        any_arrival_r <= arrival;
        any_id_r      <= item_r.entry_id;
      end
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  // a priority pick is always also a candidate for the plain pick
  a_prio_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    prio_valid_r |-> any_valid_r)
    else $error("priority pick held without a plain pick");

  a_any_not_younger: assert property (@(posedge clk) disable iff (!rst_n)
    (prio_valid_r && any_valid_r) |-> (any_arrival_r <= prio_arrival_r))
    else $error("plain pick younger than priority pick");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |->
      (out_r.chosen_id == 7'd0 && !out_r.chose_write && !out_r.was_priority))
    else $error("empty result carries non-zero fields");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit)
    else $error("result overwritten while stalled");

endmodule

[src/dram_request_picker_write_drain.sv]
// ---------------------------------------------------------------------------
// dram_request_picker_write_drain_core: DRAM request picker with write drain
// Top level joining the sequencing controller and the picker datapath.
// ---------------------------------------------------------------------------
// Words are taken one at a time. A start word steps through capture and decode
// (drain flag update), an entry word through capture, age/row-hit judgement and
// compare with the two running picks, and a finish word through capture, decode
// and result load, which waits while the result register is full and stalled.
// The controller steps a single held word through the age subtract of up to 48
// bits and then the arrival compares. A result sits in an output register, so
// the next word is accepted while it waits. Drain flags reset to zero;
// configuration writes land at any time.
module dram_request_picker_write_drain_core import drpwd_pkg::*; #(
  parameter int CHANNELS  = 4,
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  drpwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  drpwd_datapath #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[test/dram_request_picker_write_drain_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dram_request_picker_write_drain_core_tb: self-checking bench of the picker
// Drives start, entry and finish words through the valid/stall channel with
// random gaps and output stalls. A behavioural copy predicts each random pick,
// directed words carry theirs; every result is compared field by field in order.
// ---------------------------------------------------------------------------
module dram_request_picker_write_drain_core_tb;
  import drpwd_pkg::*;

  localparam int CHANNELS = 4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam out_item_t  NO_PICK    = '0;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    in_item_t  word;
    logic      typed;
    out_item_t want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit calm = 1'b0;
  int mismatches = 0;
  int words_sent = 0;
  out_item_t pending_picks [$];
  script_row_t script [$];

  // picker copy: registers, drain flags, latched pass and the two running picks
  logic [7:0]  high_mark = HIGH_MARK_RESET;
  logic [7:0]  low_mark  = LOW_MARK_RESET;
  logic [31:0] age_limit = AGE_RESET;
  logic        drain_flag [CHANNELS];
  logic        cur_drain = 1'b0;
  logic [47:0] cur_now = '0;
  logic        hot_valid = 1'b0;
  logic [47:0] hot_arrival = '0;
  logic [6:0]  hot_id = '0;
  logic        old_valid = 1'b0;
  logic [47:0] old_arrival = '0;
  logic [6:0]  old_id = '0;

  dram_request_picker_write_drain_core #(
    .CHANNELS (CHANNELS),
    .TIME_BITS(48)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 32);
    end
  end

  task automatic drop_picks();
    hot_valid = 1'b0;
    hot_arrival = '0;
    hot_id = '0;
    old_valid = 1'b0;
    old_arrival = '0;
    old_id = '0;
  endtask

  task automatic pick_model(input in_item_t w, output bit has_pick, output out_item_t pick);
    logic [47:0] waited;
    logic        hit;
    logic        aged;
    has_pick = 1'b0;
    pick = NO_PICK;
    case (w.command)
      CMD_START: begin
        cur_now = w.now_cycle;
        cur_drain = 1'b0;
        if (w.channel < CHANNELS) begin
          if (w.write_count > high_mark || w.read_count == 8'd0) begin
            drain_flag[w.channel] = 1'b1;
          end else if (w.write_count <= low_mark) begin
            drain_flag[w.channel] = 1'b0;
          end
          cur_drain = drain_flag[w.channel];
        end
        drop_picks();
      end
      CMD_ENTRY: begin
        if (w.is_write == cur_drain && w.issuable) begin
          hit = w.bank_active && (w.open_row == w.entry_row);
          waited = cur_now - w.arrive_cycle;
          // an arrival after the latched cycle never counts as aged
          aged = (w.arrive_cycle <= cur_now) && (waited > {16'd0, age_limit});
          if ((hit || aged) && (!hot_valid || w.arrive_cycle < hot_arrival)) begin
            hot_valid = 1'b1;
            hot_arrival = w.arrive_cycle;
            hot_id = w.entry_id;
          end
          if (!old_valid || w.arrive_cycle < old_arrival) begin
            old_valid = 1'b1;
            old_arrival = w.arrive_cycle;
            old_id = w.entry_id;
          end
        end
      end
      CMD_FINISH: begin
        has_pick = 1'b1;
        if (hot_valid) begin
          pick = '{found: 1'b1, chose_write: cur_drain, chosen_id: hot_id, was_priority: 1'b1};
        end else if (old_valid) begin
          pick = '{found: 1'b1, chose_write: cur_drain, chosen_id: old_id, was_priority: 1'b0};
        end
        drop_picks();
      end
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic in_item_t random_word();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  // queue lengths around the marks, plus the extremes
  function automatic logic [7:0] rand_count();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return high_mark;
      3: return high_mark + 8'd1;
      4: return low_mark;
      5: return low_mark + 8'd1;
      default: return 8'($urandom_range(0, 128));
    endcase
  endfunction

  function automatic in_item_t random_entry(input logic [47:0] prev);
    in_item_t    w;
    int unsigned span;
    w = random_word();
    w.command = CMD_ENTRY;
    w.is_write = ($urandom_range(0, 4) == 0) ? ~cur_drain : cur_drain;
    w.issuable = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 1) == 1) begin
      w.entry_row = w.open_row;
    end
    span = (age_limit > 32'd100000) ? 200000 : age_limit * 2 + 2;
    case ($urandom_range(0, 9))
      0: w.arrive_cycle = rand48();
      1: w.arrive_cycle = cur_now + 48'($urandom_range(1, 50));
      2: w.arrive_cycle = prev;
      3: w.arrive_cycle = cur_now - {16'd0, age_limit};
      4: w.arrive_cycle = cur_now - {16'd0, age_limit} - 48'd1;
      default: w.arrive_cycle = cur_now - 48'($urandom_range(0, span));
    endcase
    return w;
  endfunction

  task automatic send_word(input in_item_t w, input logic typed, input out_item_t want);
    bit        has_pick;
    out_item_t pick;
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    pick_model(w, has_pick, pick);
    if (has_pick) begin
      pending_picks.push_back(typed ? want : pick);
    end
    if (w.command != CMD_UNUSED) begin
      words_sent++;
    end
  endtask

  task automatic run_pass();
    in_item_t    w;
    logic [47:0] prev;
    int          n;
    w = random_word();
    w.command = CMD_START;
    w.read_count = rand_count();
    w.write_count = rand_count();
    if ($urandom_range(0, 1) == 1) begin
      w.now_cycle = 48'($urandom_range(0, 300000));
    end
    send_word(w, 1'b0, NO_PICK);
    prev = rand48();
    n = $urandom_range(0, 8);
    repeat (n) begin
      w = random_entry(prev);
      prev = w.arrive_cycle;
      send_word(w, 1'b0, NO_PICK);
    end
    w = random_word();
    w.command = CMD_FINISH;
    send_word(w, 1'b0, NO_PICK);
  endtask

  // hold until every pick is back and the last entry has left the pipe
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_HIGH_MARK: high_mark = value[7:0];
      REG_LOW_MARK:  low_mark = value[7:0];
      REG_AGE:       age_limit = value;
      default: ;
    endcase
  endtask

  function automatic in_item_t mk_start(input logic [1:0] ch, input logic [7:0] rd,
                                        input logic [7:0] wr, input logic [47:0] now);
    in_item_t w;
    w = '0;
    w.command = CMD_START;
    w.channel = ch;
    w.read_count = rd;
    w.write_count = wr;
    w.now_cycle = now;
    return w;
  endfunction

  function automatic in_item_t mk_entry(input logic wr, input logic iss, input logic act,
                                        input logic [15:0] orow, input logic [15:0] erow,
                                        input logic [47:0] arr, input logic [6:0] id);
    in_item_t w;
    w = '0;
    w.command = CMD_ENTRY;
    w.is_write = wr;
    w.issuable = iss;
    w.bank_active = act;
    w.open_row = orow;
    w.entry_row = erow;
    w.arrive_cycle = arr;
    w.entry_id = id;
    return w;
  endfunction

  function automatic in_item_t mk_finish();
    in_item_t w;
    w = '0;
    w.command = CMD_FINISH;
    return w;
  endfunction

  function automatic out_item_t mk_pick(input logic wr, input logic [6:0] id, input logic prio);
    return '{found: 1'b1, chose_write: wr, chosen_id: id, was_priority: prio};
  endfunction

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected pick word, expected none, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        check_field("found", 7'(want.found), 7'(out_data.found));
        check_field("chose_write", 7'(want.chose_write), 7'(out_data.chose_write));
        check_field("chosen_id", want.chosen_id, out_data.chosen_id);
        check_field("was_priority", 7'(want.was_priority), 7'(out_data.was_priority));
      end
    end
  end

  initial begin
    logic [7:0]  high_set [6];
    logic [7:0]  low_set  [6];
    logic [31:0] age_set  [6];
    in_item_t    w;
    int          goal;
    high_set = '{8'd80, 8'd0, 8'd128, 8'd64, 8'd20, 8'd255};
    low_set  = '{8'd40, 8'd0, 8'd128, 8'd32, 8'd100, 8'd0};
    age_set  = '{32'd10000, 32'd0, 32'hFFFF_FFFF, 32'd200, 32'd1000, 32'd1};
    for (int c = 0; c < CHANNELS; c++) drain_flag[c] = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset marks 80/40, age limit 10000
    script.push_back({mk_finish(), 1'b1, NO_PICK});
    script.push_back({mk_start(2'd0, 8'd10, 8'd50, 48'd1000), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b0, 1'b1, 1'b1, 16'd7, 16'd7, 48'd900, 7'd5), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b0, 1'b1, 1'b1, 16'd7, 16'd8, 48'd100, 7'd7), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b1, 1'b1, 1'b1, 16'd3, 16'd3, 48'd0, 7'd9), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b0, 1'b0, 1'b1, 16'd3, 16'd3, 48'd50, 7'd11), 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, mk_pick(1'b0, 7'd5, 1'b1)});
    // no reads waiting: drain at the top of the time range, tie on arrival
    script.push_back({mk_start(2'd1, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b1, 1'b1, 1'b0, 16'd1, 16'd2, 48'd0, 7'd127), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b1, 1'b1, 1'b0, 16'd1, 16'd2, 48'd0, 7'd3), 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, mk_pick(1'b1, 7'd127, 1'b1)});
    // write count at the low mark ends the drain; arrival after now is not aged
    script.push_back({mk_start(2'd1, 8'd5, 8'd40, 48'd20000), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 48'd30000, 7'd1), 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, mk_pick(1'b0, 7'd1, 1'b0)});
    script.push_back({mk_start(2'd2, 8'd255, 8'd255, 48'd0), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 48'd0, 7'd0), 1'b0, NO_PICK});
    w = '1;
    script.push_back({w, 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, mk_pick(1'b1, 7'd0, 1'b0)});
    // entry between passes keeps the last pass settings
    script.push_back({mk_entry(1'b1, 1'b1, 1'b1, 16'd9, 16'd9, 48'd5, 7'd60), 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, mk_pick(1'b1, 7'd60, 1'b1)});
    script.push_back({mk_start(2'd3, 8'd128, 8'd81, 48'd10000), 1'b0, NO_PICK});
    script.push_back({mk_entry(1'b1, 1'b1, 1'b1, 16'd4, 16'd4, 48'd10000, 7'd2), 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, mk_pick(1'b1, 7'd2, 1'b1)});
    // between the marks the drain flag holds
    script.push_back({mk_start(2'd3, 8'd1, 8'd41, 48'd10001), 1'b0, NO_PICK});
    script.push_back({mk_finish(), 1'b1, NO_PICK});
    foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].want);

    for (int p = 0; p < 6; p++) begin
      quiesce();
      write_reg(REG_HIGH_MARK, {24'd0, high_set[p]});
      write_reg(REG_LOW_MARK, {24'd0, low_set[p]});
      write_reg(REG_AGE, age_set[p]);
      if (p == 0) begin
        write_reg(REG_NONE, 32'hFFFF_FFFF);
      end
      cfg_we <= 1'b0;
      calm = (p == 3);
      goal = words_sent + 308;
      while (words_sent < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(random_word(), 1'b0, NO_PICK);
        end else begin
          run_pass();
        end
      end
    end

    calm = 1'b0;
    quiesce();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
src/drpwd_pkg.sv
src/drpwd_ctrl.sv
src/drpwd_datapath.sv
src/dram_request_picker_write_drain.sv
test/dram_request_picker_write_drain_core_tb.sv
